// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the ir pulse decoder rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is high
`define IRPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define IRPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/irpd_pkg.sv -----
// types and constants of the ir pulse decoder
// no dependencies; imported by irpd_front, irpd_back and the top level
`default_nettype none

package irpd_pkg;

  localparam int unsigned LEN_W  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 8;

  localparam logic [LEN_W-1:0] END_MIN    = LEN_W'(250);
  localparam logic [LEN_W-1:0] LEADER_MIN = LEN_W'(200);
  localparam logic [LEN_W-1:0] REPEAT_MIN = LEN_W'(100);
  localparam logic [LEN_W-1:0] ONE_MIN    = LEN_W'(50);
  localparam logic [LEN_W-1:0] ZERO_MIN   = LEN_W'(10);

  typedef enum logic [2:0] {
    CLS_SHORT,
    CLS_ZERO,
    CLS_ONE,
    CLS_REPEAT,
    CLS_LEADER,
    CLS_END
  } pulse_class_t;

  typedef struct packed {
    logic [WORD_W-1:0] frame_word;
    logic              frame_ready;
    logic [CNT_W-1:0]  repeat_count;
    logic [CNT_W-1:0]  burst_count;
    logic              burst_end;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/irpd_queue.sv -----
// small first-in first-out queue of register entries
// no package dependency; uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module irpd_queue #(
  parameter type item_t = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t data_in,
  output logic       full,
  input  wire logic  pop,
  output item_t      data_out,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `IRPD_ASSERT(a_count_bound, clk, rst, count <= CNT_FULL, "queue count over depth")
  `IRPD_ASSERT(a_pop_drains, clk, rst, (do_pop && !do_push) |=> count == $past(count) - 1'b1, "pop without push did not drain")

endmodule

`default_nettype wire

// ----- hw/rtl/irpd_front.sv -----
// front end: takes pulse lengths and classifies them into a register stage
// depends on irpd_pkg
`default_nettype none

module irpd_front import irpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [LEN_W-1:0] pulse_len,
  output logic                  full,
  output logic                  cls_valid,
  output pulse_class_t          cls,
  input  wire logic             cls_full
);

  pulse_class_t cls_next;
  logic         take;

  always_comb begin
    if (pulse_len >= END_MIN) begin
      cls_next = CLS_END;
    end else if (pulse_len >= LEADER_MIN) begin
      cls_next = CLS_LEADER;
    end else if (pulse_len >= REPEAT_MIN) begin
      cls_next = CLS_REPEAT;
    end else if (pulse_len >= ONE_MIN) begin
      cls_next = CLS_ONE;
    end else if (pulse_len >= ZERO_MIN) begin
      cls_next = CLS_ZERO;
    end else begin
      cls_next = CLS_SHORT;
    end
  end

  // stage frees up whenever its item moves into the queue
  assign full = cls_valid && cls_full;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (take) begin
      cls <= cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else begin
      cls_valid <= take || (cls_valid && cls_full);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/irpd_back.sv -----
// back end: holds the decoder state and builds one result per class
// depends on irpd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module irpd_back import irpd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cls_empty,
  input  wire pulse_class_t cls,
  output logic              cls_pop,
  input  wire logic         res_full,
  output logic              res_push,
  output result_t           res
);

  logic              leader_seen;
  logic              bit_value;
  logic [WORD_W-1:0] shift_word;
  logic [CNT_W-1:0]  repeats;
  logic [CNT_W-1:0]  bursts;

  logic              leader_seen_next;
  logic              bit_value_next;
  logic [WORD_W-1:0] shift_word_next;
  logic [CNT_W-1:0]  repeats_next;
  logic [CNT_W-1:0]  bursts_next;
  logic              ended;
  logic              is_repeat;

  assign cls_pop  = !cls_empty && !res_full;
  assign res_push = cls_pop;

  always_comb begin
    is_repeat        = (cls == CLS_REPEAT);
    ended            = is_repeat || (cls == CLS_END);
    leader_seen_next = leader_seen;
    bit_value_next   = bit_value;
    shift_word_next  = shift_word;
    repeats_next     = is_repeat ? repeats + 1'b1 : repeats;
    bursts_next      = is_repeat ? bursts + 1'b1 : bursts;
    unique case (cls)
      CLS_END, CLS_REPEAT: begin
        leader_seen_next = 1'b0;
        bit_value_next   = 1'b0;
      end
      CLS_LEADER: leader_seen_next = 1'b1;
      CLS_ONE:    bit_value_next   = 1'b1;
      CLS_ZERO:   bit_value_next   = 1'b0;
      default:    bit_value_next   = bit_value;
    endcase
    if (!ended && leader_seen_next) begin
      shift_word_next = {shift_word[WORD_W-2:0], bit_value_next};
      repeats_next    = '0;
      bursts_next     = CNT_W'(1);
    end
    res.frame_word   = shift_word_next;
    res.frame_ready  = is_repeat;
    res.repeat_count = repeats_next;
    res.burst_count  = bursts_next;
    res.burst_end    = ended;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_seen <= 1'b0;
      bit_value   <= 1'b0;
      shift_word  <= '0;
      repeats     <= '0;
      bursts      <= '0;
    end else if (cls_pop) begin
      leader_seen <= leader_seen_next;
      bit_value   <= bit_value_next;
      shift_word  <= shift_word_next;
      repeats     <= repeats_next;
      bursts      <= bursts_next;
    end
  end

  `IRPD_ASSERT(a_ready_ends, clk, rst, (res_push && res.frame_ready) |-> res.burst_end, "frame ready without burst end")
  `IRPD_ASSERT(a_close_clears, clk, rst, (res_push && res.burst_end) |=> (!leader_seen && !bit_value), "burst close left state set")

endmodule

`default_nettype wire

// ----- hw/rtl/ir_remote_pulse_decoder.sv -----
// a pulse reaches the outputs via front stage register, class queue and result queue
// throughput: one pulse per cycle; front stage, class queue and result queue each move one
// item a cycle, and the back end stalls only while the result queue is full
// reset: rst is synchronous, active high; clears the decoder state and both queues
// top level of the ir pulse decoder; depends on irpd_pkg, irpd_front, irpd_queue, irpd_back
`default_nettype none

module ir_remote_pulse_decoder import irpd_pkg::*; #(
  parameter int unsigned CLASS_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [LEN_W-1:0]  pulse_len,
  input  wire logic              pop,
  output logic                   empty,
  output logic [WORD_W-1:0]      frame_word,
  output logic                   frame_ready,
  output logic [CNT_W-1:0]       repeat_count,
  output logic [CNT_W-1:0]       burst_count,
  output logic                   burst_end
);

  logic         cls_valid;
  pulse_class_t cls_stage;
  logic         cls_full;
  logic         cls_empty;
  pulse_class_t cls_head;
  logic         cls_pop;
  logic         res_full;
  logic         res_push;
  result_t      res_in;
  result_t      res_out;

  irpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pulse_len (pulse_len),
    .full      (full),
    .cls_valid (cls_valid),
    .cls       (cls_stage),
    .cls_full  (cls_full)
  );

  irpd_queue #(
    .item_t (pulse_class_t),
    .DEPTH  (CLASS_DEPTH)
  ) u_cls_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cls_valid),
    .data_in  (cls_stage),
    .full     (cls_full),
    .pop      (cls_pop),
    .data_out (cls_head),
    .empty    (cls_empty)
  );

  irpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_empty (cls_empty),
    .cls       (cls_head),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  irpd_queue #(
    .item_t (result_t),
    .DEPTH  (RESULT_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (res_in),
    .full     (res_full),
    .pop      (pop),
    .data_out (res_out),
    .empty    (empty)
  );

  assign frame_word   = res_out.frame_word;
  assign frame_ready  = res_out.frame_ready;
  assign repeat_count = res_out.repeat_count;
  assign burst_count  = res_out.burst_count;
  assign burst_end    = res_out.burst_end;

endmodule

`default_nettype wire
